### rtl/assert_macros.svh
// Assertion helpers shared by the receiver modules.
// Both expect a clock named clk in scope; the first also expects rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only out of reset.
`define SFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Checked at every edge, reset included.
`define SFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

### rtl/sfr_pkg.sv
`default_nettype none

package sfr_pkg;

  localparam int unsigned SEQ_BIT = 7;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_FLAG_BYTE    = 3'd0,
    CFG_ADDR_COMMAND = 3'd1,
    CFG_ADDR_REPLY   = 3'd2,
    CFG_SET_CODE     = 3'd3,
    CFG_UA_CODE      = 3'd4,
    CFG_DISC_CODE    = 3'd5,
    CFG_RR_CODE      = 3'd6,
    CFG_REJ_CODE     = 3'd7
  } cfg_idx_t;

  // Reset values
  localparam logic [7:0] RST_FLAG_BYTE    = 8'd126;
  localparam logic [7:0] RST_ADDR_COMMAND = 8'd3;
  localparam logic [7:0] RST_ADDR_REPLY   = 8'd1;
  localparam logic [7:0] RST_SET_CODE     = 8'd3;
  localparam logic [7:0] RST_UA_CODE      = 8'd7;
  localparam logic [7:0] RST_DISC_CODE    = 8'd11;
  localparam logic [6:0] RST_RR_CODE      = 7'd5;
  localparam logic [6:0] RST_REJ_CODE     = 7'd1;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_RR      = 3'd1,
    ST_REJ     = 3'd2,
    ST_TIMEOUT = 3'd3,
    ST_BADADDR = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] flag_byte;
    logic [7:0] addr_command;
    logic [7:0] addr_reply;
    logic [7:0] set_code;
    logic [7:0] ua_code;
    logic [7:0] disc_code;
    logic [6:0] rr_code;
    logic [6:0] rej_code;
  } sfr_cfg_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] address_byte;
    logic [7:0] control_byte;
  } sfr_result_t;

endpackage

`default_nettype wire

### rtl/sfr_cfg_regs.sv
`default_nettype none

module sfr_cfg_regs (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_we,
  input  wire logic [2:0]      cfg_index,
  input  wire logic [7:0]      cfg_wdata,
  output sfr_pkg::sfr_cfg_t    cfg
);
  import sfr_pkg::*;

  sfr_cfg_t cfg_r;
  sfr_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FLAG_BYTE:    cfg_nxt.flag_byte    = cfg_wdata;
        CFG_ADDR_COMMAND: cfg_nxt.addr_command = cfg_wdata;
        CFG_ADDR_REPLY:   cfg_nxt.addr_reply   = cfg_wdata;
        CFG_SET_CODE:     cfg_nxt.set_code     = cfg_wdata;
        CFG_UA_CODE:      cfg_nxt.ua_code      = cfg_wdata;
        CFG_DISC_CODE:    cfg_nxt.disc_code    = cfg_wdata;
        CFG_RR_CODE:      cfg_nxt.rr_code      = cfg_wdata[6:0];
        CFG_REJ_CODE:     cfg_nxt.rej_code     = cfg_wdata[6:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flag_byte    <= RST_FLAG_BYTE;
      cfg_r.addr_command <= RST_ADDR_COMMAND;
      cfg_r.addr_reply   <= RST_ADDR_REPLY;
      cfg_r.set_code     <= RST_SET_CODE;
      cfg_r.ua_code      <= RST_UA_CODE;
      cfg_r.disc_code    <= RST_DISC_CODE;
      cfg_r.rr_code      <= RST_RR_CODE;
      cfg_r.rej_code     <= RST_REJ_CODE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

### rtl/sfr_parser.sv
`default_nettype none

module sfr_parser (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire sfr_pkg::sfr_cfg_t cfg,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             in_kind,
  input  wire logic [7:0]       in_rx_byte,
  input  wire logic             in_expected_seq,
  input  wire logic             out_ready,
  output logic                  res_load,
  output sfr_pkg::sfr_result_t  res
);
  import sfr_pkg::*;

  `include "assert_macros.svh"

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_FLAG = 5'b00010,
    PH_ADDR = 5'b00100,
    PH_CTRL = 5'b01000,
    PH_BCC  = 5'b10000
  } phase_t;

  // input register
  logic       s1_valid_r, s1_valid_nxt;
  logic       s1_kind_r;
  logic [7:0] s1_byte_r;
  logic       s1_seq_r;

  // frame state
  phase_t     phase_r, phase_nxt;
  logic [7:0] held_address_r, held_address_nxt;
  logic [7:0] held_control_r, held_control_nxt;

  logic       s1_load;
  logic       s1_fire;
  logic       emit;
  logic       is_flag;
  logic       addr_ok;
  logic       ctrl_ok;
  logic [7:0] rr_full;
  logic [7:0] rej_full;

  assign rr_full  = {s1_seq_r, cfg.rr_code};
  assign rej_full = {s1_seq_r, cfg.rej_code};
  assign is_flag  = (s1_byte_r == cfg.flag_byte);
  assign addr_ok  = (s1_byte_r == cfg.addr_command) || (s1_byte_r == cfg.addr_reply);
  assign ctrl_ok  = (s1_byte_r == cfg.set_code) || (s1_byte_r == cfg.ua_code) ||
                    (s1_byte_r == cfg.disc_code) || (s1_byte_r == rr_full) ||
                    (s1_byte_r == rej_full);

  always_comb begin
    phase_nxt        = PH_IDLE;
    held_address_nxt = held_address_r;
    held_control_nxt = held_control_r;
    emit             = 1'b0;
    res.status       = ST_OK;
    res.address_byte = 8'd0;
    res.control_byte = 8'd0;
    if (s1_kind_r) begin
      emit       = 1'b1;
      res.status = ST_TIMEOUT;
    end else begin
      case (phase_r)
        PH_FLAG: begin
          if (addr_ok) begin
            held_address_nxt = s1_byte_r;
            phase_nxt        = PH_ADDR;
          end else if (is_flag) begin
            phase_nxt = PH_FLAG;
          end else begin
            emit       = 1'b1;
            res.status = ST_BADADDR;
          end
        end
        PH_ADDR: begin
          if (ctrl_ok) begin
            held_control_nxt = s1_byte_r;
            phase_nxt        = PH_CTRL;
          end else if (is_flag) begin
            phase_nxt = PH_FLAG;
          end
        end
        PH_CTRL: begin
          if (s1_byte_r == (held_address_r ^ held_control_r)) begin
            phase_nxt = PH_BCC;
          end else if (is_flag) begin
            phase_nxt = PH_FLAG;
          end
        end
        PH_BCC: begin
          if (is_flag) begin
            emit             = 1'b1;
            res.address_byte = held_address_r;
            res.control_byte = held_control_r;
            // REJ takes precedence when both codes match
            if (held_control_r == rej_full) begin
              res.status = ST_REJ;
            end else if (held_control_r == rr_full) begin
              res.status = ST_RR;
            end
          end
        end
        default: begin
          phase_nxt = is_flag ? PH_FLAG : PH_IDLE;
        end
      endcase
    end
  end

  // An item leaves the input register when its result, if any, has a place to go.
  assign s1_fire      = s1_valid_r && (!emit || out_ready);
  assign in_stall     = s1_valid_r && !s1_fire;
  assign s1_load      = in_valid && !in_stall;
  assign res_load     = s1_fire && emit;
  assign s1_valid_nxt = s1_load || (s1_valid_r && !s1_fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      phase_r        <= PH_IDLE;
      held_address_r <= 8'd0;
      held_control_r <= 8'd0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (s1_fire) begin
        phase_r        <= phase_nxt;
        held_address_r <= held_address_nxt;
        held_control_r <= held_control_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_kind_r <= in_kind;
      s1_byte_r <= in_rx_byte;
      s1_seq_r  <= in_expected_seq;
    end
  end

  `SFR_ASSERT(a_timeout_to_idle, s1_fire && s1_kind_r |=> phase_r == PH_IDLE,
              "timeout did not return the receiver to idle")
  `SFR_ASSERT(a_frame_from_bcc,
              res_load && res.status != ST_TIMEOUT && res.status != ST_BADADDR
              |-> phase_r == PH_BCC,
              "frame reported outside the check byte phase")
  `SFR_ASSERT(a_badaddr_from_flag, res_load && res.status == ST_BADADDR |-> phase_r == PH_FLAG,
              "bad address reported outside the flag phase")

endmodule

`default_nettype wire

### rtl/sfr_out_reg.sv
`default_nettype none

module sfr_out_reg (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            res_load,
  input  wire sfr_pkg::sfr_result_t res,
  output logic                 out_ready,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [2:0]           out_status,
  output logic [7:0]           out_address_byte,
  output logic [7:0]           out_control_byte
);
  import sfr_pkg::*;

  `include "assert_macros.svh"

  logic        out_valid_r, out_valid_nxt;
  sfr_result_t res_r;

  assign out_ready     = !out_valid_r || !out_stall;
  assign out_valid_nxt = res_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = res_r.status;
  assign out_address_byte = res_r.address_byte;
  assign out_control_byte = res_r.control_byte;

  `SFR_ASSERT_ALWAYS(a_no_overwrite, out_valid_r && out_stall |-> !res_load,
                     "held result overwritten while stalled")

endmodule

`default_nettype wire

### rtl/supervisory_frame_receiver_unit.sv
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------------
//  in      | input     | in_valid / in_stall | in_kind, in_rx_byte, in_expected_seq
//  out     | output    | out_valid/out_stall | out_status, out_address_byte,
//          |           |                     | out_control_byte
//  cfg     | input     | cfg_we              | cfg_index, cfg_wdata
//
//  One byte or timeout event per cycle unless in_stall is high; a result passes
//  through the input register, then the result register, before it is presented.
//  Between the two registers lie the frame state update, a byte compare and XOR step.
//  rst_n is synchronous, active low; clears phase, held bytes, valids; resets config.
//  An out_stall holds the result register; an event that reports nothing still drains
//  from the input register while the output is stalled.
`default_nettype none

module supervisory_frame_receiver_unit (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // byte / timeout events
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_kind,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       in_expected_seq,
  // frame reports
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      out_status,
  output logic [7:0]      out_address_byte,
  output logic [7:0]      out_control_byte,
  // register writes
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_wdata
);
  import sfr_pkg::*;

  sfr_cfg_t    cfg;
  sfr_result_t res;
  logic        res_load;
  logic        out_ready;

  // delimiter, addresses and control codes
  sfr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // input register plus the frame state machine
  sfr_parser u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_rx_byte      (in_rx_byte),
    .in_expected_seq (in_expected_seq),
    .out_ready       (out_ready),
    .res_load        (res_load),
    .res             (res)
  );

  // result register; frees the parser when empty or when the consumer takes a transfer
  sfr_out_reg u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .res_load         (res_load),
    .res              (res),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_address_byte (out_address_byte),
    .out_control_byte (out_control_byte)
  );

endmodule

`default_nettype wire
